>>> hdl/sdm_pkg.sv
package sdm_pkg;

  localparam int unsigned MAX_PAIRS_DEF = 1024;
  localparam int unsigned VAL_W  = 17;
  localparam int unsigned DIST_W = 27;
  localparam int unsigned SIM_W  = 37;
  localparam int unsigned USED_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_DIST,
    ST_MERGE,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // per-cycle control of one sorting row
  typedef struct packed {
    logic shift;  // move every entry one place toward the head
    logic rot;    // tail takes the head entry instead of an empty one
    logic clr;    // drop every entry
  } row_ctl_t;

endpackage

>>> hdl/sorted_list_distance_and_match_score_core.sv
// channel | ports                                          | dir
// in      | in_valid/in_ready, left/right value, last_pair  | sink
// out     | out_valid/out_ready, sums, pairs_used, overflow | source
//
// one pair per cycle while loading; left and right values each ride a systolic insertion row
// after the closing pair: the rows settle, then rotate fully for the distance
// sum, then merge for the similarity sum, then pass the flush state and the
// load state, the load waiting while the output register still holds an
// unaccepted result; input is held off meanwhile
// the result sits in an output register, so the next set loads while it waits
// synchronous active-low reset empties both rows and the pair count
module sorted_list_distance_and_match_score_core #(
  parameter int unsigned MAX_PAIRS = sdm_pkg::MAX_PAIRS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdm_pkg::VAL_W-1:0]     in_left_value,
  input  logic [sdm_pkg::VAL_W-1:0]     in_right_value,
  input  logic                          in_last_pair,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdm_pkg::DIST_W-1:0]    out_distance_sum,
  output logic [sdm_pkg::SIM_W-1:0]     out_similarity_sum,
  output logic [sdm_pkg::USED_W-1:0]    out_pairs_used,
  output logic                          out_overflow
);

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned PW = sdm_pkg::VAL_W + CW;

  sdm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                 cnt_r, cnt_nxt;     // pairs stored
  logic                          drop_r, drop_nxt;
  logic [CW-1:0]                 cyc_r, cyc_nxt;     // phase counter
  logic [sdm_pkg::DIST_W-1:0]    dist_r, dist_nxt;
  logic [sdm_pkg::SIM_W-1:0]     sim_r, sim_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [sdm_pkg::VAL_W-1:0]     run_v_r, run_v_nxt;  // last right value popped
  logic                          run_ok_r, run_ok_nxt;
  logic [CW-1:0]                 run_c_r, run_c_nxt;  // how often it occurred

  logic                          ov_r, ov_nxt;
  logic [sdm_pkg::DIST_W-1:0]    od_r, od_nxt;
  logic [sdm_pkg::SIM_W-1:0]     os_r, os_nxt;
  logic [sdm_pkg::USED_W-1:0]    ou_r, ou_nxt;
  logic                          oo_r, oo_nxt;

  sdm_pkg::row_ctl_t             lctl, rctl;
  logic                          ins_vld;
  logic [sdm_pkg::VAL_W-1:0]     lh, rh, diff;
  logic                          lh_vld, rh_vld;
  logic                          in_acc;

  assign in_ready = (state_r == sdm_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ins_vld  = in_acc && (cnt_r < CW'(MAX_PAIRS));
  assign diff     = (lh > rh) ? (lh - rh) : (rh - lh);

  sdm_row #(.DEPTH(MAX_PAIRS)) u_left (
    .clk (clk), .rst_n (rst_n), .ctl (lctl),
    .in_val (in_left_value), .in_vld (ins_vld),
    .head_val (lh), .head_vld (lh_vld)
  );

  sdm_row #(.DEPTH(MAX_PAIRS)) u_right (
    .clk (clk), .rst_n (rst_n), .ctl (rctl),
    .in_val (in_right_value), .in_vld (ins_vld),
    .head_val (rh), .head_vld (rh_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdm_pkg::ST_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyc_r    <= cyc_nxt;
    dist_r   <= dist_nxt;
    sim_r    <= sim_nxt;
    prod_r   <= prod_nxt;
    run_v_r  <= run_v_nxt;
    run_ok_r <= run_ok_nxt;
    run_c_r  <= run_c_nxt;
    od_r     <= od_nxt;
    os_r     <= os_nxt;
    ou_r     <= ou_nxt;
    oo_r     <= oo_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    cyc_nxt    = cyc_r;
    dist_nxt   = dist_r;
    sim_nxt    = sim_r;
    prod_nxt   = '0;
    run_v_nxt  = run_v_r;
    run_ok_nxt = run_ok_r;
    run_c_nxt  = run_c_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    os_nxt     = os_r;
    ou_nxt     = ou_r;
    oo_nxt     = oo_r;
    lctl       = '0;
    rctl       = '0;

    if (out_valid && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      sdm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (ins_vld) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_pair) begin
            state_nxt  = sdm_pkg::ST_SETTLE;
            cyc_nxt    = '0;
            dist_nxt   = '0;
            sim_nxt    = '0;
            run_ok_nxt = 1'b0;
            run_c_nxt  = '0;
          end
        end
      end
      // let in-flight beats reach their cells
      sdm_pkg::ST_SETTLE: begin
        cyc_nxt = cyc_r + CW'(1);
        if (cyc_r == CW'(MAX_PAIRS - 1)) begin
          state_nxt = sdm_pkg::ST_DIST;
          cyc_nxt   = '0;
        end
      end
      // full rotation, rank by rank
      sdm_pkg::ST_DIST: begin
        lctl.shift = 1'b1;
        lctl.rot   = 1'b1;
        rctl.shift = 1'b1;
        rctl.rot   = 1'b1;
        if (lh_vld && rh_vld) begin
          dist_nxt = dist_r + sdm_pkg::DIST_W'(diff);
        end
        cyc_nxt = cyc_r + CW'(1);
        if (cyc_r == CW'(MAX_PAIRS - 1)) begin
          state_nxt = sdm_pkg::ST_MERGE;
        end
      end
      // merge: pop right while not above left head, else pop left and score; flush once left is empty
      sdm_pkg::ST_MERGE: begin
        sim_nxt = sim_r + sdm_pkg::SIM_W'(prod_r);
        if (!lh_vld) begin
          lctl.clr  = 1'b1;
          rctl.clr  = 1'b1;
          state_nxt = sdm_pkg::ST_FLUSH;
        end else if (rh_vld && (rh <= lh)) begin
          rctl.shift = 1'b1;
          if (run_ok_r && (run_v_r == rh)) begin
            run_c_nxt = run_c_r + CW'(1);
          end else begin
            run_v_nxt  = rh;
            run_ok_nxt = 1'b1;
            run_c_nxt  = CW'(1);
          end
        end else begin
          lctl.shift = 1'b1;
          if (run_ok_r && (run_v_r == lh)) begin
            prod_nxt = PW'(lh) * PW'(run_c_r);
          end
        end
      end
      sdm_pkg::ST_FLUSH: begin
        sim_nxt   = sim_r + sdm_pkg::SIM_W'(prod_r);
        state_nxt = sdm_pkg::ST_DONE;
      end
      sdm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = dist_r;
          os_nxt    = sim_r;
          ou_nxt    = sdm_pkg::USED_W'(cnt_r);
          oo_nxt    = drop_r;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = sdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid          = ov_r;
  assign out_distance_sum   = od_r;
  assign out_similarity_sum = os_r;
  assign out_pairs_used     = ou_r;
  assign out_overflow       = oo_r;

  // both rows hold the same number of entries and rotate in lockstep
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdm_pkg::ST_DIST) |-> (lh_vld == rh_vld))
    else $error("rows out of step during distance pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PAIRS))
    else $error("pair count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdm_pkg::ST_MERGE && !lh_vld) |=> (state_r == sdm_pkg::ST_FLUSH))
    else $error("merge did not end on empty left row");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdm_pkg::ST_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("result not loaded");

endmodule

>>> hdl/sdm_cell.sv
module sdm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdm_pkg::row_ctl_t             ctl,
  input  logic [sdm_pkg::VAL_W-1:0]     in_val,
  input  logic                          in_vld,
  input  logic [sdm_pkg::VAL_W-1:0]     nb_val,
  input  logic                          nb_vld,
  output logic [sdm_pkg::VAL_W-1:0]     val,
  output logic                          vld,
  output logic [sdm_pkg::VAL_W-1:0]     fwd_val,
  output logic                          fwd_vld
);

  logic [sdm_pkg::VAL_W-1:0] val_r, fwd_r;
  logic                      vld_r, fvld_r;

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= nb_val;
    end else if (in_vld) begin
      if (!vld_r) begin
        val_r <= in_val;
      end else if (in_val < val_r) begin
        val_r <= in_val;
        fwd_r <= val_r;
      end else begin
        fwd_r <= in_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r  <= 1'b0;
      fvld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r  <= nb_vld;
      fvld_r <= 1'b0;
    end else begin
      fvld_r <= in_vld && vld_r;
      if (in_vld) begin
        vld_r <= 1'b1;
      end
    end
  end

  assign val     = val_r;
  assign vld     = vld_r;
  assign fwd_val = fwd_r;
  assign fwd_vld = fvld_r;

endmodule

>>> hdl/sdm_row.sv
module sdm_row #(
  parameter int unsigned DEPTH = sdm_pkg::MAX_PAIRS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdm_pkg::row_ctl_t             ctl,
  input  logic [sdm_pkg::VAL_W-1:0]     in_val,
  input  logic                          in_vld,
  output logic [sdm_pkg::VAL_W-1:0]     head_val,
  output logic                          head_vld
);

  logic [sdm_pkg::VAL_W-1:0] val   [DEPTH];
  logic                      vld   [DEPTH];
  logic [sdm_pkg::VAL_W-1:0] fval  [DEPTH];
  logic                      fvld  [DEPTH];
  logic [sdm_pkg::VAL_W-1:0] ival  [DEPTH];
  logic                      ivld  [DEPTH];
  logic [sdm_pkg::VAL_W-1:0] nval  [DEPTH];
  logic                      nvld  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign ival[i] = in_val;
      assign ivld[i] = in_vld && !ctl.shift;
    end else begin : g_mid
      assign ival[i] = fval[i-1];
      assign ivld[i] = fvld[i-1] && !ctl.shift;
    end
    if (i == DEPTH-1) begin : g_tail
      assign nval[i] = val[0];
      assign nvld[i] = ctl.rot && vld[0];
    end else begin : g_body
      assign nval[i] = val[i+1];
      assign nvld[i] = vld[i+1];
    end
    sdm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .in_val  (ival[i]),
      .in_vld  (ivld[i]),
      .nb_val  (nval[i]),
      .nb_vld  (nvld[i]),
      .val     (val[i]),
      .vld     (vld[i]),
      .fwd_val (fval[i]),
      .fwd_vld (fvld[i])
    );
  end

  assign head_val = val[0];
  assign head_vld = vld[0];

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CAP       = sdm_pkg::MAX_PAIRS_DEF;
  // settle + rotate + merge of a full set, with margin for receiver stalls
  localparam int unsigned SET_CYC   = 4 * CAP + 64;
  localparam longint      CYC_LIMIT = 3000000;

  typedef struct packed {
    logic [sdm_pkg::VAL_W-1:0] left;
    logic [sdm_pkg::VAL_W-1:0] right;
    logic                      last;
  } pair_t;

  typedef struct packed {
    logic [sdm_pkg::DIST_W-1:0] dsum;
    logic [sdm_pkg::SIM_W-1:0]  sim;
    logic [sdm_pkg::USED_W-1:0] used;
    logic                       ovf;
  } score_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [sdm_pkg::VAL_W-1:0] in_left_value;
  logic [sdm_pkg::VAL_W-1:0] in_right_value;
  logic in_last_pair;
  logic out_valid;
  logic out_ready;
  logic [sdm_pkg::DIST_W-1:0] out_distance_sum;
  logic [sdm_pkg::SIM_W-1:0]  out_similarity_sum;
  logic [sdm_pkg::USED_W-1:0] out_pairs_used;
  logic out_overflow;

  sorted_list_distance_and_match_score_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_left_value      (in_left_value),
    .in_right_value     (in_right_value),
    .in_last_pair       (in_last_pair),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance_sum   (out_distance_sum),
    .out_similarity_sum (out_similarity_sum),
    .out_pairs_used     (out_pairs_used),
    .out_overflow       (out_overflow)
  );

  // pairs waiting to be driven, scores waiting to come out
  pair_t  pair_q[$];
  score_t score_q[$];

  // predictor copy of the set being collected
  logic [sdm_pkg::VAL_W-1:0] set_left[$];
  logic [sdm_pkg::VAL_W-1:0] set_right[$];
  logic                      set_dropped;

  int     n_errors;
  int     n_beats_in;
  int     n_scores;
  int     n_total;
  int     n_sets_ovf;
  longint cyc;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // score of a closed set: sorted rank-by-rank distance and match score
  function automatic score_t score_set();
    logic [sdm_pkg::VAL_W-1:0] ls[$];
    logic [sdm_pkg::VAL_W-1:0] rs[$];
    int unsigned               hits[logic [sdm_pkg::VAL_W-1:0]];
    logic [63:0]               dacc;
    logic [63:0]               sim;
    score_t                    s;
    dacc = '0;
    sim  = '0;
    ls = set_left;
    rs = set_right;
    ls.sort();
    rs.sort();
    foreach (rs[k]) begin
      if (hits.exists(rs[k])) hits[rs[k]]++;
      else hits[rs[k]] = 1;
    end
    foreach (ls[k]) begin
      dacc += (ls[k] > rs[k]) ? 64'(ls[k] - rs[k]) : 64'(rs[k] - ls[k]);
      if (hits.exists(ls[k])) sim += 64'(ls[k]) * 64'(hits[ls[k]]);
    end
    s.dsum = dacc[sdm_pkg::DIST_W-1:0];
    s.sim  = sim[sdm_pkg::SIM_W-1:0];
    s.used = sdm_pkg::USED_W'(ls.size());
    s.ovf  = set_dropped;
    return s;
  endfunction

  // track one accepted pair; a closing pair yields one expected score
  function automatic void take_pair(pair_t p);
    if (set_left.size() < CAP) begin
      set_left.push_back(p.left);
      set_right.push_back(p.right);
    end else begin
      set_dropped = 1'b1;
    end
    if (p.last) begin
      score_q.push_back(score_set());
      if (set_dropped) n_sets_ovf++;
      set_left.delete();
      set_right.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // value drawn by mode: narrow band for matches, in range, or any 17 bits
  function automatic logic [sdm_pkg::VAL_W-1:0] pick_val(int mode);
    case (mode)
      0: begin
        return sdm_pkg::VAL_W'($urandom_range(15));
      end
      1: begin
        return sdm_pkg::VAL_W'($urandom_range(99999));
      end
      default: begin
        return sdm_pkg::VAL_W'($urandom);
      end
    endcase
  endfunction

  task automatic add_pair(logic [sdm_pkg::VAL_W-1:0] l, logic [sdm_pkg::VAL_W-1:0] r,
                          logic last);
    pair_t p;
    p.left  = l;
    p.right = r;
    p.last  = last;
    pair_q.push_back(p);
  endtask

  task automatic add_rand_set(int len, int mode);
    for (int k = 0; k < len; k++)
      add_pair(pick_val(mode), pick_val(mode), k == len - 1);
  endtask

  // idle share per phase: receiver-heavy, sender-heavy swapped, then none
  function automatic int phase_of();
    if (n_total == 0) return 2;
    return (n_beats_in * 3) / n_total;
  endfunction

  // driver: new beat only once the current one is taken or none is up
  always @(posedge clk) begin
    int idle_pct;
    pair_t p;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_left_value  <= '0;
      in_right_value <= '0;
      in_last_pair   <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_pair({in_left_value, in_right_value, in_last_pair});
        n_beats_in++;
      end
      if (!in_valid || in_ready) begin
        case (phase_of())
          0:       idle_pct = 32;
          1:       idle_pct = 55;
          default: idle_pct = 0;
        endcase
        if (pair_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          p = pair_q.pop_front();
          in_valid       <= 1'b1;
          in_left_value  <= p.left;
          in_right_value <= p.right;
          in_last_pair   <= p.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every score beat against the oldest expectation
  always @(posedge clk) begin
    int stall_pct;
    score_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_scores++;
        if (score_q.size() == 0) begin
          $error("score beat with no expectation pending");
          n_errors++;
        end else begin
          e = score_q.pop_front();
          if (out_distance_sum !== e.dsum) begin
            $error("distance_sum: expected %0d, got %0d", e.dsum, out_distance_sum);
            n_errors++;
          end
          if (out_similarity_sum !== e.sim) begin
            $error("similarity_sum: expected %0d, got %0d", e.sim, out_similarity_sum);
            n_errors++;
          end
          if (out_pairs_used !== e.used) begin
            $error("pairs_used: expected %0d, got %0d", e.used, out_pairs_used);
            n_errors++;
          end
          if (out_overflow !== e.ovf) begin
            $error("overflow: expected %0b, got %0b", e.ovf, out_overflow);
            n_errors++;
          end
        end
      end
      case (phase_of())
        0:       stall_pct = 55;
        1:       stall_pct = 32;
        default: stall_pct = 0;
      endcase
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int len;
    int n_rand;
    rst_n       = 1'b0;
    n_errors    = 0;
    n_beats_in  = 0;
    n_scores    = 0;
    n_total     = 0;
    n_sets_ovf  = 0;
    cyc         = 0;
    set_dropped = 1'b0;

    // directed: lone pair, extremes, full 17-bit values
    add_pair('0, '0, 1'b1);
    add_pair(sdm_pkg::VAL_W'(99999), '0, 1'b1);
    add_pair('1, '1, 1'b1);
    add_pair('0, '1, 1'b0);
    add_pair('1, '0, 1'b1);
    // duplicates on both sides drive the match score
    add_pair(sdm_pkg::VAL_W'(5), sdm_pkg::VAL_W'(7), 1'b0);
    add_pair(sdm_pkg::VAL_W'(5), sdm_pkg::VAL_W'(5), 1'b0);
    add_pair(sdm_pkg::VAL_W'(7), sdm_pkg::VAL_W'(7), 1'b1);
    // all values equal
    for (int k = 0; k < 4; k++)
      add_pair(sdm_pkg::VAL_W'(99999), sdm_pkg::VAL_W'(99999), k == 3);
    // no matches at all, lists in reverse order
    for (int k = 0; k < 5; k++)
      add_pair(sdm_pkg::VAL_W'(10 + k), sdm_pkg::VAL_W'(100 - k), k == 4);
    // alternating bit patterns
    add_pair(sdm_pkg::VAL_W'(17'h15555), sdm_pkg::VAL_W'(17'h0aaaa), 1'b0);
    add_pair(sdm_pkg::VAL_W'(17'h0aaaa), sdm_pkg::VAL_W'(17'h15555), 1'b1);

    // random sets, mostly short so the per-set scan stays cheap
    n_rand = 0;
    while (n_rand < 200) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      add_rand_set(len, ($urandom_range(7) == 0) ? 2 : $urandom_range(1));
      n_rand += len;
    end
    // store fills exactly, then overflows, closing pair itself dropped
    add_rand_set(CAP + 6, 0);
    add_rand_set(3, 1);
    n_total = pair_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pair_q.size() != 0 || in_valid || score_q.size() != 0) @(posedge clk);
    // let any stray beat show up
    repeat (SET_CYC) @(posedge clk);

    $display("%0d pairs driven, %0d scores checked, %0d sets past capacity",
             n_beats_in, n_scores, n_sets_ovf);
    $display("sets from one pair up to beyond capacity, under three idle patterns");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sorted_list_distance_and_match_score_core.f
hdl/sdm_pkg.sv
hdl/sdm_cell.sv
hdl/sdm_row.sv
hdl/sorted_list_distance_and_match_score_core.sv
verif/tb_top.sv
